// ===== rtl/core/lru_pkg.sv =====
// Shared constants and types for the LRU cache set lookup.
package lru_pkg;

  // Number of ways in the set and the stored tag width
  localparam int unsigned WAYS = 4;
  localparam int unsigned TAG_W = 64;

  // Width of an age value and of a way index (at least one bit)
  localparam int unsigned AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Oldest age a valid way may reach
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  // Outcome codes reported with each result word
  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

endpackage

// ===== rtl/core/lru_cache_set_lookup.sv =====
// Top level: one cache set with true LRU replacement, one access per cycle.
//
// Usage:
//   Drive an access tag on access_tag_i and pulse start for one cycle. The
//   word is taken at the rising edge where start is high and busy is low;
//   busy stays low, so a new access may be issued in every cycle.
//   The access is captured in an input register. In the following cycle the
//   tag is compared against all ways in parallel, the way state (valid, tag,
//   age) is updated and the outcome is registered. The result word appears
//   on outcome_o from the result register with done_o high for exactly one
//   cycle, and is taken at the edge that ends that cycle. Throughput is one
//   access per cycle, set by the single compare-and-update pass between the
//   input and result registers; each access sees the state left by the one
//   before it.
//   outcome_o: 0 hit, 1 miss filling an empty way, 2 miss with eviction.
//   The receiver cannot stall: each result word is taken in its one cycle.
//   Reset (rst_ni low, asynchronous) invalidates all ways, clears the ages
//   and drops any access in flight.
module lru_cache_set_lookup (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [lru_pkg::TAG_W-1:0]  access_tag_i,
  output logic                       done_o,
  output logic [1:0]                 outcome_o
);
  import lru_pkg::*;

  // Input register
  logic             req_vld_q;
  logic [TAG_W-1:0] req_tag_q;

  // Way state
  logic [WAYS-1:0]  way_valid_q, way_valid_d;
  logic [TAG_W-1:0] way_tag_q [WAYS];
  logic [AGE_W-1:0] way_age_q [WAYS];
  logic [AGE_W-1:0] way_age_d [WAYS];

  // Result register
  logic     done_q;
  outcome_e outcome_q, outcome_d;

  // Lookup signals
  logic             hit_found, free_found, old_found;
  logic [IDX_W-1:0] hit_idx, free_idx, old_idx, sel_idx;
  logic [AGE_W-1:0] old_age;
  logic [AGE_W:0]   age_limit;

  assign busy = 1'b0;

  // Capture the access word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      req_tag_q <= access_tag_i;
    end
  end

  // Find first hit, first free way and first oldest valid way
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    old_found  = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    old_idx    = '0;
    old_age    = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (way_valid_q[i]) begin
        if (!hit_found && way_tag_q[i] == req_tag_q) begin
          hit_found = 1'b1;
          hit_idx   = IDX_W'(i);
        end
        if (!old_found || way_age_q[i] > old_age) begin
          old_found = 1'b1;
          old_age   = way_age_q[i];
          old_idx   = IDX_W'(i);
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Pick the way to touch and the ageing limit
  always_comb begin
    priority if (hit_found) begin
      sel_idx   = hit_idx;
      age_limit = {1'b0, way_age_q[hit_idx]};
      outcome_d = OUT_HIT;
    end else if (free_found) begin
      sel_idx   = free_idx;
      age_limit = (AGE_W+1)'(WAYS);
      outcome_d = OUT_FILL;
    end else begin
      sel_idx   = old_idx;
      age_limit = (AGE_W+1)'(WAYS);
      outcome_d = OUT_EVICT;
    end
  end

  // Age the other valid ways below the ageing limit and AGE_MAX, reset the touched way to youngest and mark it valid
  always_comb begin
    way_valid_d = way_valid_q;
    for (int i = 0; i < WAYS; i++) begin
      way_age_d[i] = way_age_q[i];
      if (IDX_W'(i) == sel_idx) begin
        way_age_d[i]   = '0;
        way_valid_d[i] = 1'b1;
      end else if (way_valid_q[i] && ({1'b0, way_age_q[i]} < age_limit)
                   && (way_age_q[i] < AGE_MAX)) begin
        way_age_d[i] = way_age_q[i] + AGE_W'(1);
      end
    end
  end

  // Update control state of the ways
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      way_valid_q <= '0;
      for (int i = 0; i < WAYS; i++) begin
        way_age_q[i] <= '0;
      end
    end else if (req_vld_q) begin
      way_valid_q <= way_valid_d;
      for (int i = 0; i < WAYS; i++) begin
        way_age_q[i] <= way_age_d[i];
      end
    end
  end

  // Write the tag on a miss
  always_ff @(posedge clk_i) begin
    if (req_vld_q && !hit_found) begin
      way_tag_q[sel_idx] <= req_tag_q;
    end
  end

  // Register the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      outcome_q <= outcome_d;
    end
  end

  assign done_o    = done_q;
  assign outcome_o = outcome_q;

endmodule
